### rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a trigger in one cycle is followed by a condition in the next.
`define ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

### rtl/ooktx_pkg.sv
package ooktx_pkg;

    localparam int FRAME_BITS = 40;
    localparam int SYM_W      = $clog2(FRAME_BITS + 1);
    localparam int IDX_W      = $clog2(FRAME_BITS);

    localparam int CODE_W     = 28;
    localparam int CHANNEL_W  = 4;
    localparam int COMMAND_W  = 8;
    localparam int REPEAT_W   = 8;
    localparam int WORD_W     = CODE_W + CHANNEL_W + COMMAND_W;

    localparam int PULSE_W    = 12;
    localparam int FACTOR_W   = 6;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 3;

    localparam logic [PULSE_W-1:0]  PULSE_LENGTH_RST = 12'd360;
    localparam logic [FACTOR_W-1:0] SYNC_HIGH_RST    = 6'd12;
    localparam logic [FACTOR_W-1:0] SYNC_LOW_RST     = 6'd3;
    localparam logic [FACTOR_W-1:0] ZERO_HIGH_RST    = 6'd1;
    localparam logic [FACTOR_W-1:0] ZERO_LOW_RST     = 6'd2;
    localparam logic [FACTOR_W-1:0] ONE_HIGH_RST     = 6'd2;
    localparam logic [FACTOR_W-1:0] ONE_LOW_RST      = 6'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PULSE_LENGTH,
        REG_SYNC_HIGH,
        REG_SYNC_LOW,
        REG_ZERO_HIGH,
        REG_ZERO_LOW,
        REG_ONE_HIGH,
        REG_ONE_LOW,
        REG_INVERTED
    } cfg_reg_t;

    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_START = 1'b1
    } op_t;

    typedef struct packed {
        logic [PULSE_W-1:0]  pulse_length;
        logic [FACTOR_W-1:0] sync_high;
        logic [FACTOR_W-1:0] sync_low;
        logic [FACTOR_W-1:0] zero_high;
        logic [FACTOR_W-1:0] zero_low;
        logic [FACTOR_W-1:0] one_high;
        logic [FACTOR_W-1:0] one_low;
        logic                inverted;
    } cfg_t;

    typedef struct packed {
        logic                 operation;
        logic [CODE_W-1:0]    code_word;
        logic [CHANNEL_W-1:0] channel_number;
        logic [COMMAND_W-1:0] command_byte;
        logic [REPEAT_W-1:0]  repeat_count;
    } item_t;

    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic transmission_done;
        logic start_rejected;
    } res_t;

    typedef struct packed {
        logic             hit;
        logic [SYM_W-1:0] sym;
    } find_t;

    // Vector bit j stands for data symbol j+1. Return the first live symbol
    // above the given one.
    function automatic find_t find_next(input logic [FRAME_BITS-1:0] v,
                                        input logic [SYM_W-1:0] after);
        logic [FRAME_BITS-1:0] cand;
        logic [FRAME_BITS-1:0] low;
        find_t                 f;
        cand  = v & ({FRAME_BITS{1'b1}} << after);
        low   = cand & ((~cand) + FRAME_BITS'(1));
        f.hit = |cand;
        f.sym = '0;
        for (int j = 0; j < FRAME_BITS; j++)
        begin
            if (low[j])
            begin
                f.sym = f.sym | SYM_W'(j + 1);
            end
        end
        return f;
    endfunction

endpackage

### rtl/ooktx_stream_if.sv
interface ooktx_item_if;
    import ooktx_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 operation;
    logic [CODE_W-1:0]    code_word;
    logic [CHANNEL_W-1:0] channel_number;
    logic [COMMAND_W-1:0] command_byte;
    logic [REPEAT_W-1:0]  repeat_count;

    modport source (
        output valid, operation, code_word, channel_number, command_byte, repeat_count,
        input  ready
    );

    modport sink (
        input  valid, operation, code_word, channel_number, command_byte, repeat_count,
        output ready
    );
endinterface

interface ooktx_result_if;
    logic valid;
    logic ready;
    logic line_level;
    logic busy_res;
    logic transmission_done;
    logic start_rejected;

    modport source (
        output valid, line_level, busy_res, transmission_done, start_rejected,
        input  ready
    );

    modport sink (
        input  valid, line_level, busy_res, transmission_done, start_rejected,
        output ready
    );
endinterface

### rtl/ooktx_cfg_regs.sv
module ooktx_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [ooktx_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ooktx_pkg::CFG_DATA_W-1:0]   cfg_data,
    output ooktx_pkg::cfg_t                    cfg
);
    import ooktx_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_PULSE_LENGTH: cfg_next.pulse_length = cfg_data[PULSE_W-1:0];
                REG_SYNC_HIGH:    cfg_next.sync_high    = cfg_data[FACTOR_W-1:0];
                REG_SYNC_LOW:     cfg_next.sync_low     = cfg_data[FACTOR_W-1:0];
                REG_ZERO_HIGH:    cfg_next.zero_high    = cfg_data[FACTOR_W-1:0];
                REG_ZERO_LOW:     cfg_next.zero_low     = cfg_data[FACTOR_W-1:0];
                REG_ONE_HIGH:     cfg_next.one_high     = cfg_data[FACTOR_W-1:0];
                REG_ONE_LOW:      cfg_next.one_low      = cfg_data[FACTOR_W-1:0];
                REG_INVERTED:     cfg_next.inverted     = cfg_data[0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pulse_length <= PULSE_LENGTH_RST;
            cfg_reg.sync_high    <= SYNC_HIGH_RST;
            cfg_reg.sync_low     <= SYNC_LOW_RST;
            cfg_reg.zero_high    <= ZERO_HIGH_RST;
            cfg_reg.zero_low     <= ZERO_LOW_RST;
            cfg_reg.one_high     <= ONE_HIGH_RST;
            cfg_reg.one_low      <= ONE_LOW_RST;
            cfg_reg.inverted     <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/ooktx_engine.sv
`include "assert_macros.svh"

module ooktx_engine (
    input  logic             clk,
    input  logic             rst_n,
    input  ooktx_pkg::cfg_t  cfg,
    input  logic             advance,
    input  ooktx_pkg::item_t item,
    output ooktx_pkg::res_t  res
);
    import ooktx_pkg::*;

    logic [FRAME_BITS-1:0] kind_reg, kind_next;
    logic [SYM_W-1:0]      sym_reg, sym_next;
    logic                  second_reg, second_next;
    logic [PULSE_W-1:0]    tick_reg, tick_next;
    logic [FACTOR_W-1:0]   unit_reg, unit_next;
    logic [REPEAT_W-1:0]   rep_reg, rep_next;
    logic                  active_reg, active_next;

    logic [WORD_W-1:0]     word;
    logic [63:0]           word_ext;
    logic [FRAME_BITS-1:0] frame;
    logic [FRAME_BITS-1:0] fresh_kind;
    logic [FRAME_BITS-1:0] fresh_live;
    logic [FRAME_BITS-1:0] live_cur;
    logic                  live0, live1, sync_live;
    logic                  sync_start_second;
    logic [SYM_W-1:0]      sym_minus, t_minus, t0_minus, f_minus;
    logic                  kind_cur, kind_t, kind_t0, kind_f;
    logic [FACTOR_W-1:0]   factor_cur, factor_low;
    logic                  level_cur;
    logic [PULSE_W-1:0]    tick_inc;
    logic [FACTOR_W-1:0]   unit_inc;
    logic [REPEAT_W-1:0]   rep_dec;
    find_t                 found_run, found_start, found_first;

    // Frame is code, channel, command with the code in the top bits.
    assign word     = {item.code_word, item.channel_number, item.command_byte};
    assign word_ext = 64'(word);
    assign frame    = word_ext[FRAME_BITS-1:0];

    // Reorder so that bit j belongs to data symbol j+1 (sent MSB first).
    always_comb
    begin
        for (int j = 0; j < FRAME_BITS; j++)
        begin
            fresh_kind[j] = frame[FRAME_BITS-1-j];
        end
    end

    assign live0     = (cfg.zero_high != '0) || (cfg.zero_low != '0);
    assign live1     = (cfg.one_high != '0) || (cfg.one_low != '0);
    assign sync_live = (cfg.sync_high != '0) || (cfg.sync_low != '0);
    assign sync_start_second = (cfg.sync_high == '0);

    assign fresh_live = (fresh_kind & {FRAME_BITS{live1}}) |
                        (~fresh_kind & {FRAME_BITS{live0}});

    // Live mask follows the current settings so that writes during a frame apply at once.
    assign live_cur = (kind_reg & {FRAME_BITS{live1}}) |
                      (~kind_reg & {FRAME_BITS{live0}});

    assign found_run   = find_next(live_cur, sym_reg);
    assign found_start = find_next(fresh_live, '0);
    assign found_first = find_next(live_cur, '0);

    assign sym_minus = sym_reg - SYM_W'(1);
    assign t_minus   = found_run.sym - SYM_W'(1);
    assign t0_minus  = found_start.sym - SYM_W'(1);
    assign f_minus   = found_first.sym - SYM_W'(1);
    assign kind_cur  = kind_reg[sym_minus[IDX_W-1:0]];
    assign kind_t    = kind_reg[t_minus[IDX_W-1:0]];
    assign kind_t0   = fresh_kind[t0_minus[IDX_W-1:0]];
    assign kind_f    = kind_reg[f_minus[IDX_W-1:0]];

    always_comb
    begin
        if (sym_reg == '0)
        begin
            factor_low = cfg.sync_low;
            factor_cur = second_reg ? cfg.sync_low : cfg.sync_high;
        end
        else if (kind_cur)
        begin
            factor_low = cfg.one_low;
            factor_cur = second_reg ? cfg.one_low : cfg.one_high;
        end
        else
        begin
            factor_low = cfg.zero_low;
            factor_cur = second_reg ? cfg.zero_low : cfg.zero_high;
        end
    end

    assign level_cur = ~second_reg ^ cfg.inverted;
    assign tick_inc  = tick_reg + PULSE_W'(1);
    assign unit_inc  = unit_reg + FACTOR_W'(1);
    assign rep_dec   = rep_reg - REPEAT_W'(1);

    always_comb
    begin
        kind_next   = kind_reg;
        sym_next    = sym_reg;
        second_next = second_reg;
        tick_next   = tick_reg;
        unit_next   = unit_reg;
        rep_next    = rep_reg;
        active_next = active_reg;
        res         = '0;

        if (item.operation == OP_START)
        begin
            if (active_reg)
            begin
                res.start_rejected = 1'b1;
                res.line_level     = level_cur;
                res.busy_res       = 1'b1;
            end
            else
            begin
                kind_next   = fresh_kind;
                rep_next    = item.repeat_count;
                sym_next    = '0;
                second_next = 1'b0;
                tick_next   = '0;
                unit_next   = '0;
                if (item.repeat_count == '0)
                begin
                    res.transmission_done = 1'b1;
                end
                else if ((cfg.pulse_length == '0) || (!sync_live && !found_start.hit))
                begin
                    // Nothing in the frame takes time: finish on this item.
                    res.transmission_done = 1'b1;
                end
                else
                begin
                    active_next  = 1'b1;
                    res.busy_res = 1'b1;
                    if (sync_live)
                    begin
                        second_next = sync_start_second;
                    end
                    else
                    begin
                        sym_next    = found_start.sym;
                        second_next = kind_t0 ? (cfg.one_high == '0) : (cfg.zero_high == '0);
                    end
                    res.line_level = ~second_next ^ cfg.inverted;
                end
            end
        end
        else if (active_reg)
        begin
            res.line_level = level_cur;
            res.busy_res   = 1'b1;
            if (tick_inc >= cfg.pulse_length)
            begin
                tick_next = '0;
                if (unit_inc >= factor_cur)
                begin
                    unit_next = '0;
                    if ((cfg.pulse_length == '0) || (!sync_live && !found_first.hit))
                    begin
                        // No phase left that takes time: end the transmission here.
                        active_next           = 1'b0;
                        rep_next              = '0;
                        sym_next              = '0;
                        second_next           = 1'b0;
                        res.busy_res          = 1'b0;
                        res.transmission_done = 1'b1;
                    end
                    else if (!second_reg && (factor_low != '0))
                    begin
                        second_next = 1'b1;
                    end
                    else if (found_run.hit)
                    begin
                        sym_next    = found_run.sym;
                        second_next = kind_t ? (cfg.one_high == '0) : (cfg.zero_high == '0);
                    end
                    else
                    begin
                        // End of frame: count off one repeat.
                        rep_next = rep_dec;
                        if (rep_dec == '0)
                        begin
                            active_next           = 1'b0;
                            sym_next              = '0;
                            second_next           = 1'b0;
                            res.busy_res          = 1'b0;
                            res.transmission_done = 1'b1;
                        end
                        else if (sync_live)
                        begin
                            sym_next    = '0;
                            second_next = sync_start_second;
                        end
                        else
                        begin
                            sym_next    = found_first.sym;
                            second_next = kind_f ? (cfg.one_high == '0) : (cfg.zero_high == '0);
                        end
                    end
                end
                else
                begin
                    unit_next = unit_inc;
                end
            end
            else
            begin
                tick_next = tick_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg   <= '0;
            sym_reg    <= '0;
            second_reg <= 1'b0;
            tick_reg   <= '0;
            unit_reg   <= '0;
            rep_reg    <= '0;
            active_reg <= 1'b0;
        end
        else if (advance)
        begin
            kind_reg   <= kind_next;
            sym_reg    <= sym_next;
            second_reg <= second_next;
            tick_reg   <= tick_next;
            unit_reg   <= unit_next;
            rep_reg    <= rep_next;
            active_reg <= active_next;
        end
    end

    `ASSERT_ALWAYS(a_sym_range, !active_reg || (sym_reg <= SYM_W'(FRAME_BITS)), "symbol out of range")
    `ASSERT_NEXT(a_done_idle, advance && res.transmission_done, !active_reg, "active after done")
    `ASSERT_NEXT(a_reject_hold, advance && res.start_rejected, active_reg && $stable(sym_reg) && $stable(tick_reg) && $stable(unit_reg), "rejected start moved state")

endmodule

### rtl/ook_pulse_frame_transmitter_core.sv
// On-off-keyed pulse frame transmitter.
// item_ch carries items: a start loads code, channel, command and a repeat
// count; a tick advances the radio line by one tick. result_ch returns one
// result per item: the line level driven during that item, busy, done and
// start-rejected flags. The frame is a sync symbol and then the data bits,
// MSB first; each symbol is a first and a second phase of configured length.
// The user is to write registers through cfg_we / cfg_index / cfg_data only
// with no item in flight; the block does not enforce this, and a write during
// a transmission takes effect at once. The result passes through the input
// register and then the result register before it is valid. Throughput: one
// item per cycle while result_ch is ready; every item is finished by
// combinational logic between the two registers, and phases of zero length are
// jumped over by a find-first search on the live-symbol mask.
// Reset: registers return to their defaults, the line is idle (low) and no
// transmission is active.
// Stall: while result_ch is not ready the result is held and the input
// register takes one more item, then item_ch ready drops until the result
// is taken.
module ook_pulse_frame_transmitter_core (
    input  logic                             clk,
    input  logic                             rst_n,
    ooktx_item_if.sink                       item_ch,
    ooktx_result_if.source                   result_ch,
    input  logic                             cfg_we,
    input  logic [ooktx_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ooktx_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ooktx_pkg::*;

    cfg_t  cfg;
    item_t item_reg;
    logic  item_valid_reg, item_valid_next;
    res_t  res;
    res_t  res_reg;
    logic  res_valid_reg, res_valid_next;
    logic  advance;
    logic  take;

    ooktx_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ooktx_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .advance (advance),
        .item    (item_reg),
        .res     (res)
    );

    assign advance       = item_valid_reg && (!res_valid_reg || result_ch.ready);
    assign item_ch.ready = !item_valid_reg || advance;
    assign take          = item_ch.valid && item_ch.ready;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (take)
        begin
            item_valid_next = 1'b1;
        end
        else if (advance)
        begin
            item_valid_next = 1'b0;
        end

        res_valid_next = res_valid_reg;
        if (advance)
        begin
            res_valid_next = 1'b1;
        end
        else if (result_ch.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    // Payload registers: the item loads on handshake, the result on advance; no reset.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.operation      <= item_ch.operation;
            item_reg.code_word      <= item_ch.code_word;
            item_reg.channel_number <= item_ch.channel_number;
            item_reg.command_byte   <= item_ch.command_byte;
            item_reg.repeat_count   <= item_ch.repeat_count;
        end
        if (advance)
        begin
            res_reg <= res;
        end
    end

    assign result_ch.valid             = res_valid_reg;
    assign result_ch.line_level        = res_reg.line_level;
    assign result_ch.busy_res          = res_reg.busy_res;
    assign result_ch.transmission_done = res_reg.transmission_done;
    assign result_ch.start_rejected    = res_reg.start_rejected;

endmodule
